>>> hdl/three_stop_gradient_recolor_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-stop gradient recolor block
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing in synthesis. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`ifndef THREE_STOP_GRADIENT_RECOLOR_TOP_MACROS_SVH
`define THREE_STOP_GRADIENT_RECOLOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define TSGR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("tsgr assertion failed");

// antecedent implies consequent in the next cycle
`define TSGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("tsgr assertion failed");

`else

`define TSGR_ASSERT_SAME(label, ante, cons)
`define TSGR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/tsgr_pkg.sv
// ----------------------------------------------------------------------------
// tsgr_pkg
// Types and constants shared by the gradient recolor top level and its
// blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tsgr_pkg;

    // blend weight: 8 integer bits, 8 fraction bits, saturates at 255.0
    localparam int unsigned WEIGHT_W   = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 16'hFF00;

    // one color: red 23:16, green 15:8, blue 7:0
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned NCHAN   = 3;
    localparam int unsigned COLOR_W = CHAN_W * NCHAN;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DARK      = 2'd0,
        CFG_BASE      = 2'd1,
        CFG_HIGHLIGHT = 2'd2,
        CFG_GAIN      = 2'd3
    } t_cfg_idx;

    // one RGBA word as it travels down the pipeline
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_pixel;

    // stage load enables for one blend unit
    typedef struct packed {
        logic mul_en;
        logic div_en;
    } t_blend_ctl;

endpackage

`default_nettype wire

>>> hdl/tsgr_blend.sv
// ----------------------------------------------------------------------------
// tsgr_blend
// Two-stage color blend: q = floor(a + w*(b-a)/255.0) per channel, with w in
// 8.8 fixed point. Stage one forms the exact numerator, stage two divides by
// 255*256 as a shift and a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgr_blend (
    input  wire logic                           i_clk,
    input  wire tsgr_pkg::t_blend_ctl           i_ctl,
    input  wire logic [tsgr_pkg::COLOR_W-1:0]   i_a,
    input  wire logic [tsgr_pkg::COLOR_W-1:0]   i_b,
    input  wire logic [tsgr_pkg::WEIGHT_W-1:0]  i_w,
    output logic      [tsgr_pkg::COLOR_W-1:0]   o_q
);

    localparam int unsigned CW = tsgr_pkg::CHAN_W;

    // numerator per channel, never negative and at most 255*65280
    logic [23:0] r_num [tsgr_pkg::NCHAN];
    logic [23:0] n_num [tsgr_pkg::NCHAN];
    logic [CW-1:0] r_q [tsgr_pkg::NCHAN];
    logic [CW-1:0] n_q [tsgr_pkg::NCHAN];

    for (genvar c = 0; c < tsgr_pkg::NCHAN; c++) begin : g_chan
        logic [CW-1:0]     ch_a;
        logic [CW-1:0]     ch_b;
        logic signed [8:0]  diff;
        logic signed [25:0] prod;
        logic signed [25:0] base;
        logic signed [25:0] sum;
        logic [15:0]        m;
        logic [23:0]        m257;
        logic [CW-1:0]      q0;
        logic [16:0]        q255;
        logic [16:0]        rem;

        assign ch_a = i_a[c*CW +: CW];
        assign ch_b = i_b[c*CW +: CW];

        // numerator: a*255*256 + w*(b-a)
        assign diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
        assign prod = $signed({1'b0, i_w}) * diff;
        assign base = $signed({2'b00, ch_a, 16'h0000}) - $signed({10'h000, ch_a, 8'h00});
        assign sum  = base + prod;
        assign n_num[c] = sum[23:0];

        // divide by 256 (shift) then by 255 (reciprocal 257/65536, fix-up)
        assign m    = r_num[c][23:8];
        assign m257 = {m, 8'h00} + {8'h00, m};
        assign q0   = m257[23:16];
        assign q255 = {1'b0, q0, 8'h00} - {9'h000, q0};
        assign rem  = {1'b0, m} - q255;
        assign n_q[c] = (rem >= 17'd255) ? q0 + 8'd1 : q0;

        assign o_q[c*CW +: CW] = r_q[c];
    end

    // numerator stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_num <= n_num;
        end
    end

    // quotient stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.div_en) begin
            r_q <= n_q;
        end
    end

endmodule

`default_nettype wire

>>> hdl/three_stop_gradient_recolor_top.sv
// ----------------------------------------------------------------------------
// three_stop_gradient_recolor_top
// Pipeline: 5 register stages, from the weight stage 0 to output stage 4.
// Throughput: one word per cycle while not stalled; the 5 stages each hold
// a word and bubbles collapse, so a stall backs up only when all are full.
// Reset (synchronous, active low) clears stage valids and loads the default
// stops (black, mid gray, white) and unity gain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_stop_gradient_recolor_top_macros.svh"

module three_stop_gradient_recolor_top #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    // input words
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_red,
    input  wire logic [7:0]  i_in_green,
    input  wire logic [7:0]  i_in_blue,
    input  wire logic [7:0]  i_in_alpha,
    // output words
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic [7:0]       o_out_alpha
);

    localparam int unsigned NSTG = 5;
    localparam int unsigned UP   = (GAIN_FRAC_BITS < 8) ? 8 - GAIN_FRAC_BITS : 0;
    localparam int unsigned DOWN = (GAIN_FRAC_BITS > 8) ? GAIN_FRAC_BITS - 8 : 0;
    localparam int unsigned WW   = tsgr_pkg::WEIGHT_W;
    localparam int unsigned CLW  = tsgr_pkg::COLOR_W;

    // rescale a green*gain product to 8.8 and saturate at 255.0
    function automatic logic [WW-1:0] make_weight(input logic [19:0] p);
        logic [23:0] s;
        s = ({4'h0, p} << UP) >> DOWN;
        return (s > {8'h00, tsgr_pkg::WEIGHT_MAX}) ? tsgr_pkg::WEIGHT_MAX : s[WW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CLW-1:0] r_dark_color;
    logic [CLW-1:0] r_base_color;
    logic [CLW-1:0] r_highlight_color;
    logic [11:0]    r_blend_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_color      <= 24'h000000;
            r_base_color      <= 24'h808080;
            r_highlight_color <= 24'hFFFFFF;
            r_blend_gain      <= 12'd256;
        end else if (i_cfg_we) begin
            unique case (tsgr_pkg::t_cfg_idx'(i_cfg_idx))
                tsgr_pkg::CFG_DARK:      r_dark_color      <= i_cfg_data;
                tsgr_pkg::CFG_BASE:      r_base_color      <= i_cfg_data;
                tsgr_pkg::CFG_HIGHLIGHT: r_highlight_color <= i_cfg_data;
                tsgr_pkg::CFG_GAIN:      r_blend_gain      <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage control: a stage loads when it is empty or its word moves on
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   rdy;

    assign rdy[NSTG] = !i_stall;
    for (genvar k = 0; k < NSTG; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: weights from green and gain
    // ------------------------------------------------------------------
    tsgr_pkg::t_pixel in_pix;
    logic [19:0]      prod_w1;
    logic [19:0]      prod_w2;
    logic [WW-1:0]    r_w1;
    logic [WW-1:0]    r_w2 [3];
    tsgr_pkg::t_pixel r_pix [NSTG];

    assign in_pix = '{red: i_in_red, green: i_in_green, blue: i_in_blue, alpha: i_in_alpha};

    // green above 128 leaves green[6:0] = green - 128; at 128 that is zero
    assign prod_w1 = {12'h000, i_in_green} * {8'h00, r_blend_gain};
    assign prod_w2 = i_in_green[7] ? {13'h0000, i_in_green[6:0]} * {8'h00, r_blend_gain}
                                   : 20'h00000;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_pix[0] <= in_pix;
            r_w1     <= make_weight(prod_w1);
            r_w2[0]  <= make_weight(prod_w2);
        end
        for (int k = 1; k < NSTG; k++) begin
            if (rdy[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
        for (int k = 1; k < 3; k++) begin
            if (rdy[k]) begin
                r_w2[k] <= r_w2[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 1-2: dark toward base; stages 3-4: that toward highlight
    // ------------------------------------------------------------------
    tsgr_pkg::t_blend_ctl ctl_lo;
    tsgr_pkg::t_blend_ctl ctl_hi;
    logic [CLW-1:0]       mid_color;
    logic [CLW-1:0]       fin_color;

    assign ctl_lo = '{mul_en: rdy[1], div_en: rdy[2]};
    assign ctl_hi = '{mul_en: rdy[3], div_en: rdy[4]};

    tsgr_blend u_blend_lo (
        .i_clk (i_clk),
        .i_ctl (ctl_lo),
        .i_a   (r_dark_color),
        .i_b   (r_base_color),
        .i_w   (r_w1),
        .o_q   (mid_color)
    );

    tsgr_blend u_blend_hi (
        .i_clk (i_clk),
        .i_ctl (ctl_hi),
        .i_a   (mid_color),
        .i_b   (r_highlight_color),
        .i_w   (r_w2[2]),
        .o_q   (fin_color)
    );

    // ------------------------------------------------------------------
    // output: transparent pixels pass through untouched
    // ------------------------------------------------------------------
    logic pass_thru;
    assign pass_thru = (r_pix[NSTG-1].alpha == 8'h00);

    assign o_out_red   = pass_thru ? r_pix[NSTG-1].red   : fin_color[23:16];
    assign o_out_green = pass_thru ? r_pix[NSTG-1].green : fin_color[15:8];
    assign o_out_blue  = pass_thru ? r_pix[NSTG-1].blue  : fin_color[7:0];
    assign o_out_alpha = r_pix[NSTG-1].alpha;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // upstream only sees a stall once every stage holds a word
    `TSGR_ASSERT_SAME(a_stall_full, o_stall, (&r_vld))
    // a word taken in and none delivered adds exactly one to occupancy
    `TSGR_ASSERT_NEXT(a_occ_up, (in_acc && !out_acc), ($countones(r_vld) == $countones($past(r_vld)) + 1))
    // a word delivered and none taken in removes exactly one
    `TSGR_ASSERT_NEXT(a_occ_dn, (!in_acc && out_acc), ($countones(r_vld) + 1 == $countones($past(r_vld))))

endmodule

`default_nettype wire

>>> dv/three_stop_gradient_recolor_top_tb.sv
// ----------------------------------------------------------------------------
// three_stop_gradient_recolor_top_tb
// Self-checking bench for the three-stop gradient recolor block. A directed
// table covers pass-through, black and saturated weights, reversed stops and
// register masking. Random phases then reprogram the stops and gain and push
// pixel words through with bursty input and a random output stall. Every
// output word is checked against an in-bench model of the two-stage blend.
// ----------------------------------------------------------------------------
`default_nettype none

module three_stop_gradient_recolor_top_tb;

    localparam int     GAIN_FRAC    = 8;
    localparam int     PIPE_LATENCY = 5;
    localparam longint MIX_DIV      = 255 * 256;
    localparam int     NUM_PHASES   = 8;
    localparam int     PHASE_WORDS  = 112;
    localparam int     NUM_STEPS    = 26;

    typedef enum logic {STEP_WORD, STEP_REG} t_step_kind;

    // one row of the directed table
    typedef struct {
        t_step_kind         kind;
        tsgr_pkg::t_cfg_idx reg_idx;
        logic [23:0]        reg_data;
        tsgr_pkg::t_pixel   px;
        logic               typed;
        tsgr_pkg::t_pixel   want;
    } t_step;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    logic [7:0]  i_in_red   = '0;
    logic [7:0]  i_in_green = '0;
    logic [7:0]  i_in_blue  = '0;
    logic [7:0]  i_in_alpha = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_alpha;

    // model copy of the registers, at reset values
    logic [23:0] cur_dark      = 24'h000000;
    logic [23:0] cur_base      = 24'h808080;
    logic [23:0] cur_highlight = 24'hFFFFFF;
    logic [11:0] cur_gain      = 12'd256;

    tsgr_pkg::t_pixel pending_pixels[$];
    int     mismatch_count = 0;
    int     burst_left     = 0;
    int     stall_mode     = 0;
    int     stall_left     = 0;

    // directed table: typed expectations only where they are obvious
    t_step dir_steps [NUM_STEPS] = '{
        // default stops: zero alpha passes through, zero green gives black
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h12345600, 1'b1, 32'h12345600},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'hFFFFFF00, 1'b1, 32'hFFFFFF00},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h00000000, 1'b1, 32'h00000000},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'hAA0055FF, 1'b1, 32'h000000FF},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h00800001, 1'b0, 32'h0},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h00810080, 1'b0, 32'h0},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h55FFAAFF, 1'b0, 32'h0},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'hFF7FFFFE, 1'b0, 32'h0},
        // highlight below base, max gain; upper data bits must be dropped
        '{STEP_REG,  tsgr_pkg::CFG_DARK,      24'h0A141E, 32'h0,        1'b0, 32'h0},
        '{STEP_REG,  tsgr_pkg::CFG_BASE,      24'hF0C8A0, 32'h0,        1'b0, 32'h0},
        '{STEP_REG,  tsgr_pkg::CFG_HIGHLIGHT, 24'h123456, 32'h0,        1'b0, 32'h0},
        '{STEP_REG,  tsgr_pkg::CFG_GAIN,      24'hABCFFF, 32'h0,        1'b0, 32'h0},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h00FF0001, 1'b1, 32'h12345601},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'hFF81FFFF, 1'b0, 32'h0},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h001000FF, 1'b1, 32'hF0C8A0FF},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h008000FF, 1'b1, 32'hF0C8A0FF},
        // zero gain: words with nonzero alpha land on the dark stop
        '{STEP_REG,  tsgr_pkg::CFG_GAIN,      24'h000000, 32'h0,        1'b0, 32'h0},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h33FF33FF, 1'b1, 32'h0A141EFF},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h3301337F, 1'b1, 32'h0A141E7F},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h9C63C600, 1'b1, 32'h9C63C600},
        // smallest gain, then unity gain with masked upper bits
        '{STEP_REG,  tsgr_pkg::CFG_GAIN,      24'h000001, 32'h0,        1'b0, 32'h0},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h00FF00FF, 1'b0, 32'h0},
        '{STEP_REG,  tsgr_pkg::CFG_GAIN,      24'hFFF100, 32'h0,        1'b0, 32'h0},
        '{STEP_REG,  tsgr_pkg::CFG_DARK,      24'hFFFFFF, 32'h0,        1'b0, 32'h0},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h00C000FF, 1'b0, 32'h0},
        '{STEP_WORD, tsgr_pkg::CFG_DARK,      24'h0,      32'h5A2B7C01, 1'b0, 32'h0}
    };

    three_stop_gradient_recolor_top #(
        .GAIN_FRAC_BITS (GAIN_FRAC)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );

    always #4 i_clk = ~i_clk;

    // rescale a gain product to 8 fraction bits and saturate at 255.0
    function automatic logic [15:0] gradient_weight(input logic [31:0] product);
        logic [63:0] w;
        if (GAIN_FRAC < 8) begin
            w = 64'(product) << (8 - GAIN_FRAC);
        end else begin
            w = 64'(product) >> (GAIN_FRAC - 8);
        end
        if (w > 64'(tsgr_pkg::WEIGHT_MAX)) begin
            w = 64'(tsgr_pkg::WEIGHT_MAX);
        end
        return w[15:0];
    endfunction

    // floor(a + w*(b-a)/255) with w in 8.8, per channel
    function automatic logic [23:0] mix_color(input logic [23:0] a, input logic [23:0] b,
                                              input logic [15:0] w);
        logic [23:0] res;
        longint      n;
        for (int c = 0; c < 3; c++) begin
            n = longint'(a[c*8 +: 8]) * MIX_DIV
                + longint'(w) * (longint'(b[c*8 +: 8]) - longint'(a[c*8 +: 8]));
            if (n < 0) begin
                n = 0;
            end
            res[c*8 +: 8] = 8'(n / MIX_DIV);
        end
        return res;
    endfunction

    // expected output word for one input pixel under the current registers
    function automatic tsgr_pkg::t_pixel recolor_pixel(input tsgr_pkg::t_pixel px);
        tsgr_pkg::t_pixel res;
        logic [15:0]      w_lo;
        logic [15:0]      w_hi;
        logic [23:0]      mid;
        logic [23:0]      fin;
        res = px;
        if (px.alpha != 8'd0) begin
            w_lo = gradient_weight(32'(px.green) * 32'(cur_gain));
            w_hi = gradient_weight((px.green > 8'd128)
                                   ? (32'(px.green) - 32'd128) * 32'(cur_gain) : 32'd0);
            mid  = mix_color(cur_dark, cur_base, w_lo);
            fin  = mix_color(mid, cur_highlight, w_hi);
            res.red   = fin[23:16];
            res.green = fin[15:8];
            res.blue  = fin[7:0];
        end
        return res;
    endfunction

    function automatic void apply_reg(input tsgr_pkg::t_cfg_idx idx,
                                      input logic [23:0] data);
        case (idx)
            tsgr_pkg::CFG_DARK:      cur_dark      = data;
            tsgr_pkg::CFG_BASE:      cur_base      = data;
            tsgr_pkg::CFG_HIGHLIGHT: cur_highlight = data;
            tsgr_pkg::CFG_GAIN:      cur_gain      = data[11:0];
            default: ;
        endcase
    endfunction

    function automatic logic [23:0] pick_color();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // present one word, hold it until taken, then queue its expected result
    task automatic send_word(input tsgr_pkg::t_pixel px, input tsgr_pkg::t_pixel want_px);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_in_red   <= px.red;
        i_in_green <= px.green;
        i_in_blue  <= px.blue;
        i_in_alpha <= px.alpha;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_pixels.push_back(want_px);
    endtask

    // stop sending and let the pipeline empty
    task automatic drain_words();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input tsgr_pkg::t_cfg_idx idx, input logic [23:0] data);
        drain_words();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic check_chan(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: mismatch on %s: expected %02h, actual %02h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver stall: modes from never to mostly stalled, switched now and then
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 150);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // output checker: compare each taken word against the oldest expectation
    always @(posedge i_clk) begin
        tsgr_pkg::t_pixel want_px;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected output word %02h %02h %02h %02h", $time,
                         o_out_red, o_out_green, o_out_blue, o_out_alpha);
                mismatch_count++;
            end else begin
                want_px = pending_pixels.pop_front();
                check_chan("red",   want_px.red,   o_out_red);
                check_chan("green", want_px.green, o_out_green);
                check_chan("blue",  want_px.blue,  o_out_blue);
                check_chan("alpha", want_px.alpha, o_out_alpha);
            end
        end
    end

    // stimulus
    initial begin
        tsgr_pkg::t_pixel px;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_steps[i]) begin
            if (dir_steps[i].kind == STEP_REG) begin
                write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_data);
            end else begin
                send_word(dir_steps[i].px, dir_steps[i].typed ? dir_steps[i].want
                                                              : recolor_pixel(dir_steps[i].px));
            end
        end

        // random phases, each with fresh stops and gain
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(tsgr_pkg::CFG_DARK, pick_color());
            write_reg(tsgr_pkg::CFG_BASE, pick_color());
            write_reg(tsgr_pkg::CFG_HIGHLIGHT, pick_color());
            case ($urandom_range(0, 5))
                0:       write_reg(tsgr_pkg::CFG_GAIN, {12'($urandom), 12'h000});
                1:       write_reg(tsgr_pkg::CFG_GAIN, {12'($urandom), 12'hFFF});
                2:       write_reg(tsgr_pkg::CFG_GAIN, {12'($urandom), 12'h100});
                3:       write_reg(tsgr_pkg::CFG_GAIN,
                                   {12'($urandom), 12'($urandom_range(0, 511))});
                default: write_reg(tsgr_pkg::CFG_GAIN, 24'($urandom));
            endcase
            for (int k = 0; k < PHASE_WORDS; k++) begin
                px = tsgr_pkg::t_pixel'($urandom);
                // bias alpha toward zero and full, green toward the midpoint and ends
                case ($urandom_range(0, 7))
                    0:       px.alpha = 8'h00;
                    1:       px.alpha = 8'hFF;
                    default: ;
                endcase
                case ($urandom_range(0, 15))
                    0, 1:    px.green = 8'($urandom_range(127, 129));
                    2:       px.green = 8'h00;
                    3:       px.green = 8'hFF;
                    default: ;
                endcase
                send_word(px, recolor_pixel(px));
            end
        end

        drain_words();
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #(8 * 400_000);
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/tsgr_pkg.sv
hdl/tsgr_blend.sv
hdl/three_stop_gradient_recolor_top.sv
dv/three_stop_gradient_recolor_top_tb.sv
